// ===== rtl/hlpc_pkg.sv =====
// Shared constants, types and functions of the hive lattice point counter.
// Holds the rhombus table, the row coefficient functions and field widths.
// No dependencies.
package hlpc_pkg;

    localparam int PART_W  = 6;
    localparam int N_ROWS  = 18;
    localparam int VAL_W   = 9;   // boundary labels of the hive
    localparam int RHS_W   = 12;
    localparam int NRHS_W  = 15;
    localparam int COORD_W = 9;
    localparam int REM_W   = 16;
    localparam int WID_W   = 17;
    localparam int CNT_W   = 40;
    localparam int COEF_W  = 45;
    localparam int WIDE_W  = 48;
    localparam int HS_W    = 41;
    localparam int DIM_W   = 3;
    localparam int DIL_W   = 3;
    localparam int N_DIL   = 5;
    localparam int IN_W    = 12 * PART_W;
    localparam int OUT_W   = DIM_W + 5 * CNT_W + 4 * COEF_W + HS_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [DIL_W-1:0] DIL_BASE = 3'd3;
    localparam logic [DIL_W-1:0] DIL_EXTRA = 3'd5;

    // Hive points as octal {x,y}; per rhombus: two minus corners, two plus corners.
    localparam logic [5:0] PT_X = 6'o11;
    localparam logic [5:0] PT_U = 6'o12;
    localparam logic [5:0] PT_V = 6'o21;

    localparam logic [5:0] RH_PTS [N_ROWS][4] = '{
        '{6'o10, 6'o01, 6'o00, 6'o11},
        '{6'o11, 6'o02, 6'o01, 6'o12},
        '{6'o01, 6'o11, 6'o02, 6'o10},
        '{6'o12, 6'o03, 6'o02, 6'o13},
        '{6'o02, 6'o12, 6'o03, 6'o11},
        '{6'o03, 6'o13, 6'o04, 6'o12},
        '{6'o20, 6'o11, 6'o10, 6'o21},
        '{6'o10, 6'o11, 6'o20, 6'o01},
        '{6'o21, 6'o12, 6'o11, 6'o22},
        '{6'o11, 6'o21, 6'o12, 6'o20},
        '{6'o11, 6'o12, 6'o21, 6'o02},
        '{6'o12, 6'o22, 6'o13, 6'o21},
        '{6'o12, 6'o13, 6'o22, 6'o03},
        '{6'o30, 6'o21, 6'o20, 6'o31},
        '{6'o20, 6'o21, 6'o30, 6'o11},
        '{6'o21, 6'o31, 6'o22, 6'o30},
        '{6'o21, 6'o22, 6'o31, 6'o12},
        '{6'o30, 6'o31, 6'o40, 6'o21}
    };

    typedef logic signed [NRHS_W-1:0] nrhs_t;
    typedef nrhs_t nrhs_arr_t [N_ROWS];

    typedef struct packed {
        logic issue;
        logic clear;
    } cell_ctl_t;

    function automatic logic is_inner(input logic [5:0] pt);
        return (pt == PT_X) || (pt == PT_U) || (pt == PT_V);
    endfunction

    // Coefficient of variable idx (0 = x, 1 = u, 2 = v) in rhombus k.
    function automatic logic signed [2:0] rh_coef(input int k, input int idx);
        logic signed [2:0] c;
        logic [5:0] pt;
        logic hit;
        c = 3'sd0;
        for (int j = 0; j < 4; j++) begin
            pt = RH_PTS[k][j];
            hit = (idx == 0 && pt == PT_X) || (idx == 1 && pt == PT_U) ||
                  (idx == 2 && pt == PT_V);
            if (hit) begin
                c = (j < 2) ? c - 3'sd1 : c + 3'sd1;
            end
        end
        return c;
    endfunction

    function automatic logic signed [2:0] rh_sum(input int k);
        return rh_coef(k, 0) + rh_coef(k, 1) + rh_coef(k, 2);
    endfunction

    function automatic logic [COEF_W-1:0] sat45(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi_lim;
        logic signed [WIDE_W-1:0] lo_lim;
        hi_lim = (WIDE_W'(1) <<< (COEF_W - 1)) - WIDE_W'(1);
        lo_lim = -(WIDE_W'(1) <<< (COEF_W - 1));
        if (v > hi_lim) return hi_lim[COEF_W-1:0];
        if (v < lo_lim) return lo_lim[COEF_W-1:0];
        return v[COEF_W-1:0];
    endfunction

endpackage

// ===== rtl/hive_lattice_point_counter.sv =====
// Top level of the hive lattice point counter: input register, row builder,
// scan sequencer, coefficient arithmetic and result register.
// Depends on hlpc_pkg, hlpc_cell_unit and hlpc_div6.

// One transaction in, one out. The block scans every (u,v) cell of each
// dilation n (1..3, or 1..5 with compute_extra set) at one cell per cycle in the
// shared cell evaluator; an empty triple finishes without scanning the further
// dilations. s_tready is high only between items, but a new transaction is
// taken while the previous result still waits on m_.
module hive_lattice_point_counter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,   // compute_extra
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // lam_part0..3, mu_part0..3, nu_part0..3, 6 bits each from bit 0
    input  logic [hlpc_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // dimension, count_n1..count_n5, six_times_a1, two_times_a2,
    // six_times_a3, hstar_one, norm_volume from bit 0
    output logic [hlpc_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tuser      // is_zero
);
    import hlpc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BUILD, ST_CHECK, ST_SCAN, ST_DRAIN,
        ST_COEF1, ST_COEF2, ST_DIVGO, ST_DIV, ST_FINAL
    } state_t;

    state_t                  state_reg;
    logic                    extra_reg;
    logic                    extra_item_reg;
    logic [IN_W-1:0]         parts_reg;
    logic signed [RHS_W-1:0] rhs_reg [N_ROWS];
    logic                    bad_reg;
    nrhs_arr_t               nrhs_reg;
    logic [DIL_W-1:0]        n_reg;
    logic [COORD_W-1:0]      ulo_reg, uhi_reg, vlo_reg, vhi_reg, u_reg, v_reg;
    logic [CNT_W-1:0]        cnt_reg [N_DIL];
    logic                    zero_reg;
    logic signed [WIDE_W-1:0] p3l1_reg, p3l2_reg, p18_reg, p9_reg, p5_reg, p4_reg;
    logic signed [WIDE_W-1:0] a1_reg, a2_reg, a3_reg;
    logic                    out_valid_reg;
    logic                    out_zero_reg;
    logic [OUT_W-1:0]        out_data_reg;

    logic [PART_W-1:0]       la [4];
    logic [PART_W-1:0]       mu [4];
    logic [PART_W-1:0]       nu [4];
    logic [4:0][VAL_W-1:0]   lp, mp, np;
    logic signed [RHS_W-1:0] rhs_now [N_ROWS];
    logic                    bad_now;
    cell_ctl_t               cell_ctl;
    logic                    cell_busy;
    logic [CNT_W-1:0]        cell_count;
    logic                    div_start;
    logic                    div_busy;
    logic [WIDE_W-1:0]       div_q;
    logic [WIDE_W-1:0]       a1_mag;
    logic signed [WIDE_W-1:0] l1w, l2w, l3w;
    logic [DIL_W-1:0]        last_dil;
    logic [COORD_W-1:0]      lam1, lam2, nu1, nu2;

    logic [2:0]              dim_code;
    logic signed [WIDE_W-1:0] vn;
    logic [HS_W-1:0]         hstar;
    logic [OUT_W-1:0]        result;

    function automatic logic [VAL_W-1:0] point_val(input logic [5:0] pt,
                                                   input logic [4:0][VAL_W-1:0] lpv,
                                                   input logic [4:0][VAL_W-1:0] mpv,
                                                   input logic [4:0][VAL_W-1:0] npv);
        logic [2:0] x;
        logic [2:0] y;
        x = pt[5:3];
        y = pt[2:0];
        if (is_inner(pt)) return '0;
        if (x == 3'd0) return lpv[y];
        if (y == 3'd0) return npv[x];
        return lpv[4] + mpv[x];
    endfunction

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            la[i] = parts_reg[PART_W * i +: PART_W];
            mu[i] = parts_reg[PART_W * (4 + i) +: PART_W];
            nu[i] = parts_reg[PART_W * (8 + i) +: PART_W];
        end
        lp[0] = '0;
        mp[0] = '0;
        np[0] = '0;
        for (int i = 0; i < 4; i++) begin
            lp[i + 1] = lp[i] + VAL_W'(la[i]);
            mp[i + 1] = mp[i] + VAL_W'(mu[i]);
            np[i + 1] = np[i] + VAL_W'(nu[i]);
        end
    end

    always_comb begin
        logic signed [RHS_W-1:0] cst;
        logic [VAL_W-1:0] pv;
        bad_now = 1'b0;
        for (int k = 0; k < N_ROWS; k++) begin
            cst = '0;
            for (int j = 0; j < 4; j++) begin
                pv = point_val(RH_PTS[k][j], lp, mp, np);
                if (j < 2) cst = cst - signed'(RHS_W'(pv));
                else cst = cst + signed'(RHS_W'(pv));
            end
            rhs_now[k] = -cst;
            if (rh_coef(k, 0) == 0 && rh_coef(k, 1) == 0 && rh_coef(k, 2) == 0 &&
                cst > 0) begin
                bad_now = 1'b1;
            end
        end
    end

    assign lam1 = COORD_W'(la[1]);
    assign lam2 = COORD_W'(la[2]);
    assign nu1  = COORD_W'(nu[1]);
    assign nu2  = COORD_W'(nu[2]);
    assign last_dil = extra_item_reg ? DIL_EXTRA : DIL_BASE;

    assign l1w = signed'({{(WIDE_W - CNT_W){1'b0}}, cnt_reg[0]});
    assign l2w = signed'({{(WIDE_W - CNT_W){1'b0}}, cnt_reg[1]});
    assign l3w = signed'({{(WIDE_W - CNT_W){1'b0}}, cnt_reg[2]});
    assign a1_mag = a1_reg[WIDE_W-1] ? WIDE_W'(-a1_reg) : WIDE_W'(a1_reg);

    assign cell_ctl.issue = (state_reg == ST_SCAN);
    assign cell_ctl.clear = (state_reg == ST_CHECK) ||
                            (state_reg == ST_DRAIN && !cell_busy);
    assign div_start = (state_reg == ST_DIVGO);

    hlpc_cell_unit u_cell (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cell_ctl),
        .u       (u_reg),
        .v       (v_reg),
        .nrhs    (nrhs_reg),
        .busy    (cell_busy),
        .count   (cell_count)
    );

    hlpc_div6 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (a1_mag),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Degree, normalized volume and h*1 of the finished item.
    always_comb begin
        if (a3_reg != 0) begin
            dim_code = 3'd3;
            vn = a3_reg;
        end else if (a2_reg != 0) begin
            dim_code = 3'd2;
            vn = a2_reg;
        end else if (a1_reg != 0) begin
            dim_code = 3'd1;
            vn = a1_reg[WIDE_W-1] ? -signed'(div_q) : signed'(div_q);
        end else begin
            dim_code = 3'd0;
            vn = WIDE_W'(1);
        end
        hstar = {1'b0, cnt_reg[0]} - HS_W'(dim_code + 3'd1);
        result = {sat45(vn), hstar, sat45(a3_reg), sat45(a2_reg), sat45(a1_reg),
                  cnt_reg[4], cnt_reg[3], cnt_reg[2], cnt_reg[1], cnt_reg[0], dim_code};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            extra_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) extra_reg <= cfg_wdata;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        parts_reg      <= s_tdata;
                        extra_item_reg <= extra_reg;
                        state_reg      <= ST_BUILD;
                    end
                end
                ST_BUILD: begin
                    for (int k = 0; k < N_ROWS; k++) rhs_reg[k] <= rhs_now[k];
                    bad_reg   <= bad_now;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    for (int k = 0; k < N_DIL; k++) cnt_reg[k] <= '0;
                    for (int k = 0; k < N_ROWS; k++) nrhs_reg[k] <= NRHS_W'(rhs_reg[k]);
                    n_reg   <= DIL_W'(1);
                    ulo_reg <= lam2;
                    uhi_reg <= lam1;
                    vlo_reg <= nu2;
                    vhi_reg <= nu1;
                    u_reg   <= lam2;
                    v_reg   <= nu2;
                    if (bad_reg || la[2] > la[1] || nu[2] > nu[1]) begin
                        zero_reg  <= 1'b1;
                        state_reg <= ST_FINAL;
                    end else begin
                        zero_reg  <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (v_reg == vhi_reg) begin
                        v_reg <= vlo_reg;
                        if (u_reg == uhi_reg) state_reg <= ST_DRAIN;
                        else u_reg <= u_reg + COORD_W'(1);
                    end else begin
                        v_reg <= v_reg + COORD_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!cell_busy) begin
                        cnt_reg[n_reg - DIL_W'(1)] <= cell_count;
                        if (n_reg == DIL_W'(1) && cell_count == '0) begin
                            zero_reg  <= 1'b1;
                            state_reg <= ST_FINAL;
                        end else if (n_reg == last_dil) begin
                            state_reg <= ST_COEF1;
                        end else begin
                            // advance to the next dilation
                            n_reg <= n_reg + DIL_W'(1);
                            for (int k = 0; k < N_ROWS; k++) begin
                                nrhs_reg[k] <= nrhs_reg[k] + NRHS_W'(rhs_reg[k]);
                            end
                            ulo_reg   <= ulo_reg + lam2;
                            uhi_reg   <= uhi_reg + lam1;
                            vlo_reg   <= vlo_reg + nu2;
                            vhi_reg   <= vhi_reg + nu1;
                            u_reg     <= ulo_reg + lam2;
                            v_reg     <= vlo_reg + nu2;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_COEF1: begin
                    p3l1_reg  <= (l1w <<< 1) + l1w;
                    p3l2_reg  <= (l2w <<< 1) + l2w;
                    p18_reg   <= (l1w <<< 4) + (l1w <<< 1);
                    p9_reg    <= (l2w <<< 3) + l2w;
                    p5_reg    <= (l1w <<< 2) + l1w;
                    p4_reg    <= l2w <<< 2;
                    state_reg <= ST_COEF2;
                end
                ST_COEF2: begin
                    a3_reg    <= l3w - p3l2_reg + p3l1_reg - WIDE_W'(1);
                    a2_reg    <= WIDE_W'(2) - p5_reg + p4_reg - l3w;
                    a1_reg    <= p18_reg - p9_reg + (l3w <<< 1) - WIDE_W'(11);
                    state_reg <= ST_DIVGO;
                end
                ST_DIVGO: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (!div_busy) state_reg <= ST_FINAL;
                end
                ST_FINAL: begin
                    // hold until the result register is free
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_zero_reg  <= zero_reg;
                        if (zero_reg) out_data_reg <= {{(OUT_W - DIM_W){1'b0}}, 3'b111};
                        else out_data_reg <= result;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_zero_reg;

endmodule

// ===== rtl/hlpc_cell_unit.sv =====
// Cell evaluator: one (u,v) cell a cycle through a three-stage pipeline.
// Evaluates all rhombus rows, intersects the x-interval and accumulates the count.
// Depends on hlpc_pkg.
module hlpc_cell_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hlpc_pkg::cell_ctl_t             ctl,
    input  logic [hlpc_pkg::COORD_W-1:0]    u,
    input  logic [hlpc_pkg::COORD_W-1:0]    v,
    input  hlpc_pkg::nrhs_arr_t             nrhs,
    output logic                            busy,
    output logic [hlpc_pkg::CNT_W-1:0]      count
);
    import hlpc_pkg::*;

    logic signed [REM_W-1:0] rem_reg [N_ROWS];
    logic signed [REM_W-1:0] rem_now [N_ROWS];
    logic                    v1_reg;
    logic                    v2_reg;
    logic                    ok2_reg;
    logic                    inf2_reg;
    logic [WID_W-1:0]        w2_reg;
    logic [CNT_W-1:0]        acc_reg;

    logic signed [REM_W-1:0] hi;
    logic signed [REM_W-1:0] lo;
    logic                    has_hi;
    logic                    has_lo;
    logic                    viol;
    logic signed [WID_W-1:0] width;
    logic [CNT_W:0]          sum;

    always_comb begin
        logic signed [REM_W-1:0] us;
        logic signed [REM_W-1:0] vs;
        logic signed [REM_W-1:0] t;
        us = signed'(REM_W'(u));
        vs = signed'(REM_W'(v));
        for (int k = 0; k < N_ROWS; k++) begin
            t = REM_W'(nrhs[k]);
            if (rh_coef(k, 1) > 0) t = t - us;
            else if (rh_coef(k, 1) < 0) t = t + us;
            if (rh_coef(k, 2) > 0) t = t - vs;
            else if (rh_coef(k, 2) < 0) t = t + vs;
            rem_now[k] = t;
        end
    end

    // Upper bounds come from rows with a positive rh_sum, lower from a negative one.
    always_comb begin
        hi = '0;
        lo = '0;
        has_hi = 1'b0;
        has_lo = 1'b0;
        viol = 1'b0;
        for (int k = 0; k < N_ROWS; k++) begin
            if (rh_sum(k) > 0) begin
                if (!has_hi || rem_reg[k] < hi) hi = rem_reg[k];
                has_hi = 1'b1;
            end else if (rh_sum(k) < 0) begin
                if (!has_lo || -rem_reg[k] > lo) lo = -rem_reg[k];
                has_lo = 1'b1;
            end else if (rem_reg[k] < 0) begin
                viol = 1'b1;
            end
        end
        width = signed'({hi[REM_W-1], hi}) - signed'({lo[REM_W-1], lo}) + WID_W'(1);
        sum = {1'b0, acc_reg} + {{(CNT_W + 1 - WID_W){1'b0}}, w2_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
            if (ctl.clear) begin
                acc_reg <= '0;
            end else if (v2_reg && ok2_reg) begin
                if (inf2_reg || sum > {1'b0, CNT_MAX}) acc_reg <= CNT_MAX;
                else acc_reg <= sum[CNT_W-1:0];
            end
        end
        for (int k = 0; k < N_ROWS; k++) rem_reg[k] <= rem_now[k];
        inf2_reg <= !has_hi || !has_lo;
        ok2_reg  <= !viol && (!has_hi || !has_lo || hi >= lo);
        w2_reg   <= width;
    end

    assign busy  = v1_reg | v2_reg;
    assign count = acc_reg;

endmodule

// ===== rtl/hlpc_div6.sv =====
// Divide-by-six unit for the dimension-one volume: halves the operand, then divides
// by three through a reciprocal product built on one shared 24 x 24 multiplier.
// Depends on hlpc_pkg.
module hlpc_div6 (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [hlpc_pkg::WIDE_W-1:0]  dividend,
    output logic                         busy,
    output logic [hlpc_pkg::WIDE_W-1:0]  quotient
);
    import hlpc_pkg::*;

    localparam int HALF_W = WIDE_W / 2;
    localparam int PROD_W = 2 * HALF_W;
    localparam int ACC_W  = 4 * HALF_W;
    // (2^48 - 1) / 3 is this segment repeated twice
    localparam logic [HALF_W-1:0] RECIP_SEG = 24'h555555;

    typedef enum logic [2:0] {D_IDLE, D_MUL_LO, D_MUL_HI, D_EST, D_FIX} dstate_t;

    dstate_t               state_reg;
    logic [WIDE_W-1:0]     y_reg;
    logic [ACC_W-1:0]      part_reg;
    logic [WIDE_W-1:0]     est_reg;
    logic [WIDE_W-1:0]     quo_reg;
    logic [HALF_W-1:0]     mul_a;
    logic [PROD_W-1:0]     prod;
    logic [ACC_W-1:0]      full;
    logic [WIDE_W-1:0]     resid;

    assign mul_a = (state_reg == D_MUL_HI) ? y_reg[2*HALF_W-1:HALF_W] : y_reg[HALF_W-1:0];
    assign prod  = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, RECIP_SEG};
    // y * (seg * 2^24 + seg); the top half is floor(y/3) or one less
    assign full  = part_reg + (part_reg << HALF_W);
    assign resid = y_reg - ((est_reg << 1) + est_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            unique case (state_reg)
                D_IDLE: begin
                    if (start) state_reg <= D_MUL_LO;
                end
                D_MUL_LO: state_reg <= D_MUL_HI;
                D_MUL_HI: state_reg <= D_EST;
                D_EST:    state_reg <= D_FIX;
                D_FIX:    state_reg <= D_IDLE;
                default:  state_reg <= D_IDLE;
            endcase
        end
        case (state_reg)
            D_IDLE: begin
                if (start) y_reg <= {1'b0, dividend[WIDE_W-1:1]};
            end
            D_MUL_LO: begin
                part_reg <= {{(ACC_W - PROD_W){1'b0}}, prod};
            end
            D_MUL_HI: begin
                part_reg <= part_reg + {{(ACC_W - PROD_W - HALF_W){1'b0}}, prod,
                                        {HALF_W{1'b0}}};
            end
            D_EST: begin
                est_reg <= full[ACC_W-1:2*HALF_W];
            end
            D_FIX: begin
                // bump the estimate when a whole three is left over
                quo_reg <= (resid >= WIDE_W'(3)) ? est_reg + WIDE_W'(1) : est_reg;
            end
            default: begin
            end
        endcase
    end

    assign busy     = (state_reg != D_IDLE);
    assign quotient = quo_reg;

endmodule
